// ===== src/acache_pkg.sv =====
// ----------------------------------------------------------------------------
// acache_pkg: shared types and constants for the associative cache
// Line geometry, counter limits, request and policy codes, config register
// indexes and the packed item types of the input and result channels.
// ----------------------------------------------------------------------------
package acache_pkg;

  // Geometry
  localparam int LINES      = 16;
  localparam int TAG_BITS   = 64;
  localparam int VALUE_BITS = 64;
  localparam int IDX_W      = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int POS_W      = $clog2(LINES + 1);

  // Port field widths
  localparam int FIELD_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Replacement counter
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  // Request codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_PRESET = 1'b1;

  // Policy codes
  localparam logic POL_LRU = 1'b0;
  localparam logic POL_LFU = 1'b1;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LRU_COUNT_INIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LFU_COUNT_INIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_PERIOD     = 3'd4;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] fill_value;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [FIELD_W-1:0] read_value;
    logic               line_kept;
  } out_item_t;

  // Saturating increment of a replacement counter
  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

// ===== src/assoc_cache_lru_lfu_top.sv =====
// ----------------------------------------------------------------------------
// assoc_cache_lru_lfu_top: read-only fully associative cache, LRU/LFU
// Tag/value lines with 8-bit replacement counters, scanned one line a cycle
// by a small sequencer that shares one compare/count-update unit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  in        in   in_valid / in_ready   in_data  (in_item_t)
//  out       out  out_valid / out_ready out_data (out_item_t)
//  cfg       in   cfg_wr_en             cfg_index, cfg_data
//
//  A lookup makes one pass over the tag/count memories to search, a fill
//  step, and one read-modify-write pass over the count memory. A preset
//  makes only the search pass and the fill step. The pace is set by the
//  single read port of the line memories.
//  Reset is synchronous: clears valid bits and aging timer, resets config.
//  A result waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
module assoc_cache_lru_lfu_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  acache_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output acache_pkg::out_item_t               out_data,
  input  logic                                cfg_wr_en,
  input  logic [acache_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acache_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LINES   = acache_pkg::LINES;
  localparam int IDX_W   = acache_pkg::IDX_W;
  localparam int POS_W   = acache_pkg::POS_W;
  localparam int TAG_B   = acache_pkg::TAG_BITS;
  localparam int VAL_B   = acache_pkg::VALUE_BITS;
  localparam int CNT_W   = acache_pkg::CNT_W;
  localparam int FIELD_W = acache_pkg::FIELD_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);

  // Config registers
  logic        policy_mode;
  logic [4:0]  lines_in_use;
  logic [7:0]  lru_count_init;
  logic [7:0]  lfu_count_init;
  logic [15:0] age_period;

  // Line storage
  logic [TAG_B-1:0] tag_mem [LINES];
  logic [VAL_B-1:0] val_mem [LINES];
  logic [CNT_W-1:0] cnt_mem [LINES];
  logic [LINES-1:0] line_valid;
  logic [15:0]      age_timer;

  // Sequencer
  logic [2:0]             state;
  logic [POS_W-1:0]       pos;
  logic                   rd_vld;
  logic [IDX_W-1:0]       rd_idx;
  acache_pkg::in_item_t   item;
  acache_pkg::out_item_t  res;

  // Registered memory reads
  logic [TAG_B-1:0] tag_q;
  logic [VAL_B-1:0] val_q;
  logic [CNT_W-1:0] cnt_q;

  // Search results
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [VAL_B-1:0] hit_val;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] vic_idx;
  logic [CNT_W-1:0] vic_cnt;
  logic             fill_q;
  logic [IDX_W-1:0] slot_idx;
  logic             age_q;

  // Combinational helpers
  logic [POS_W-1:0] n_eff;
  logic             en_j;
  logic             better;
  logic [CNT_W-1:0] init_cnt;
  logic [CNT_W-1:0] upd_cnt;
  logic [CNT_W-1:0] cnt_wd;
  logic [IDX_W-1:0] cnt_wa;
  logic             cnt_we;
  logic             tag_we;
  logic [IDX_W-1:0] tag_wa;
  logic             lookup;
  logic             do_fill;
  logic [IDX_W-1:0] fill_idx;
  logic [16:0]      timer_inc;
  logic             pass_end;

  // Enabled lines, saturated to the line count
  assign n_eff = (32'(lines_in_use) > LINES) ? POS_W'(LINES) : POS_W'(lines_in_use);
  assign en_j  = POS_W'(rd_idx) < n_eff;
  assign lookup = (item.req_type == acache_pkg::REQ_LOOKUP);
  assign init_cnt = (policy_mode == acache_pkg::POL_LFU) ? lfu_count_init : lru_count_init;
  assign better = (policy_mode == acache_pkg::POL_LFU) ? (cnt_q < vic_cnt) : (cnt_q > vic_cnt);
  assign pass_end = rd_vld && (rd_idx == LAST_IDX);
  assign timer_inc = {1'b0, age_timer} + 17'd1;

  // Decide whether and where the item is stored
  always_comb begin
    do_fill  = 1'b0;
    fill_idx = free_idx;
    if (!lookup) begin
      do_fill = free_found;
    end else if (!hit_found && (n_eff != '0)) begin
      do_fill  = 1'b1;
      fill_idx = free_found ? free_idx : vic_idx;
    end
  end

  // Count of the line under the update pass
  always_comb begin
    upd_cnt = cnt_q;
    if (hit_found) begin
      if (policy_mode == acache_pkg::POL_LFU) begin
        if (rd_idx == hit_idx) upd_cnt = acache_pkg::bump(cnt_q);
      end else if (rd_idx == hit_idx) begin
        upd_cnt = lru_count_init;
      end else if (en_j && line_valid[rd_idx]) begin
        upd_cnt = acache_pkg::bump(cnt_q);
      end
    end else if (fill_q && (rd_idx == slot_idx)) begin
      upd_cnt = init_cnt;
    end
    if (age_q) upd_cnt = upd_cnt >> 1;
  end

  // Count memory write port
  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = rd_idx;
    cnt_wd = upd_cnt;
    if (state == ST_UPDATE) begin
      cnt_we = rd_vld;
    end else if ((state == ST_DECIDE) && !lookup) begin
      cnt_we = do_fill;
      cnt_wa = fill_idx;
      cnt_wd = init_cnt;
    end
  end

  assign tag_we = (state == ST_DECIDE) && do_fill;
  assign tag_wa = fill_idx;

  // Line memories: one read a cycle, one tag/value write and one count write
  always_ff @(posedge clk) begin
    tag_q <= tag_mem[pos[IDX_W-1:0]];
    val_q <= val_mem[pos[IDX_W-1:0]];
    cnt_q <= cnt_mem[pos[IDX_W-1:0]];
    if (tag_we) begin
      tag_mem[tag_wa] <= item.tag[TAG_B-1:0];
      val_mem[tag_wa] <= item.fill_value[VAL_B-1:0];
    end
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
  end

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode    <= acache_pkg::POL_LRU;
      lines_in_use   <= 5'd16;
      lru_count_init <= 8'd0;
      lfu_count_init <= 8'd1;
      age_period     <= 16'd1024;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        acache_pkg::CFG_POLICY_MODE:    policy_mode    <= cfg_data[0];
        acache_pkg::CFG_LINES_IN_USE:   lines_in_use   <= cfg_data[4:0];
        acache_pkg::CFG_LRU_COUNT_INIT: lru_count_init <= cfg_data[7:0];
        acache_pkg::CFG_LFU_COUNT_INIT: lfu_count_init <= cfg_data[7:0];
        acache_pkg::CFG_AGE_PERIOD:     age_period     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Search unit: evaluate one registered line a cycle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if ((state == ST_SCAN) && rd_vld && en_j) begin
      if (line_valid[rd_idx] && !hit_found && (tag_q == item.tag[TAG_B-1:0])) begin
        hit_found <= 1'b1;
        hit_idx   <= rd_idx;
        hit_val   <= val_q;
      end
      if (!line_valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
      if ((rd_idx == '0) || better) begin
        vic_idx <= rd_idx;
        vic_cnt <= cnt_q;
      end
    end
  end

  // Sequencer, valid bits, aging timer and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pos        <= '0;
      rd_vld     <= 1'b0;
      line_valid <= '0;
      age_timer  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // free the output register once its item is taken, unless a new one loads
      if (out_valid && out_ready && (state != ST_DONE)) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          pos    <= '0;
          rd_vld <= 1'b0;
          if (in_valid) begin
            item  <= in_data;
            state <= ST_SCAN;
          end
        end
        ST_SCAN, ST_UPDATE: begin
          // advance the read pointer, drop the read once past the last line
          if (pos < POS_W'(LINES)) begin
            pos    <= pos + 1'b1;
            rd_vld <= 1'b1;
            rd_idx <= pos[IDX_W-1:0];
          end else begin
            rd_vld <= 1'b0;
          end
          if (pass_end) begin
            pos    <= '0;
            rd_vld <= 1'b0;
            state  <= (state == ST_SCAN) ? ST_DECIDE : ST_DONE;
          end
        end
        ST_DECIDE: begin
          fill_q   <= do_fill;
          slot_idx <= fill_idx;
          age_q    <= 1'b0;
          if (do_fill) line_valid[fill_idx] <= 1'b1;
          res.hit        <= lookup && hit_found;
          res.read_value <= (lookup && hit_found) ? FIELD_W'(hit_val)
                                                  : FIELD_W'(item.fill_value[VAL_B-1:0]);
          res.line_kept  <= do_fill || (lookup && hit_found);
          if (lookup) begin
            if (timer_inc >= {1'b0, age_period}) begin
              age_q     <= 1'b1;
              age_timer <= '0;
            end else begin
              age_timer <= timer_inc[15:0];
            end
            state <= ST_UPDATE;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  // A stored line is never dropped
  assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((line_valid & $past(line_valid)) == $past(line_valid)))
    else $error("valid line lost");

  // A hit always leaves the tag resident
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && res.hit |-> res.line_kept)
    else $error("hit without line kept");

  // A preset never reports a hit
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && (item.req_type == acache_pkg::REQ_PRESET) |-> !res.hit)
    else $error("preset reported a hit");

  // The aging timer stays below its period after each lookup
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) && !rd_vld |-> (age_timer < age_period) || (age_timer == '0))
    else $error("aging timer out of range");

  // Every fill, victim or free line, lands on an enabled line
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) && do_fill |-> (POS_W'(fill_idx) < n_eff))
    else $error("fill outside enabled lines");

endmodule

// ===== bench/acache_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// acache_checker: response checker for the associative cache
// Watches the request, response and register ports. Keeps its own copy of
// the line store, the replacement counters and the aging timer. Compares
// every accepted response with the one its cache model gives for the
// matching request.
// ----------------------------------------------------------------------------
module acache_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  acache_pkg::in_item_t              in_data,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  acache_pkg::out_item_t             out_data,
  input  logic                              cfg_wr_en,
  input  logic [acache_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acache_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                fail_count,
  output int                                pending
);

  // Model of the line store
  logic [acache_pkg::TAG_BITS-1:0]   line_tag_q [acache_pkg::LINES];
  logic [acache_pkg::VALUE_BITS-1:0] line_val_q [acache_pkg::LINES];
  bit                                line_vld_q [acache_pkg::LINES];
  logic [acache_pkg::CNT_W-1:0]      line_cnt_q [acache_pkg::LINES];
  logic [15:0]                       age_cnt_q;

  // Model of the registers
  logic       policy_q;
  logic [4:0] lines_q;
  logic [7:0] lru_init_q;
  logic [7:0] lfu_init_q;
  logic [15:0] age_period_q;

  // Responses owed by the cache, oldest first
  acache_pkg::out_item_t queued_resp [$];

  function automatic logic [acache_pkg::CNT_W-1:0] sat_inc(
    input logic [acache_pkg::CNT_W-1:0] c);
    return (&c) ? c : c + 8'd1;
  endfunction

  function automatic int first_free(input int n);
    int slot;
    slot = -1;
    for (int i = n - 1; i >= 0; i--)
      if (!line_vld_q[i]) slot = i;
    return slot;
  endfunction

  task automatic fill_line(input int i, input logic [acache_pkg::TAG_BITS-1:0] t,
                           input logic [acache_pkg::VALUE_BITS-1:0] v);
    line_tag_q[i] = t;
    line_val_q[i] = v;
    line_vld_q[i] = 1'b1;
    line_cnt_q[i] = (policy_q == acache_pkg::POL_LFU) ? lfu_init_q : lru_init_q;
  endtask

  // Apply one request to the model and work out its response
  task automatic serve_request(input acache_pkg::in_item_t req,
                               output acache_pkg::out_item_t resp);
    int n;
    int slot;
    int hit_idx;
    logic [acache_pkg::TAG_BITS-1:0] t;
    logic [acache_pkg::VALUE_BITS-1:0] v;
    logic [16:0] next_age;
    n = (lines_q > acache_pkg::LINES) ? acache_pkg::LINES : int'(lines_q);
    t = req.tag[acache_pkg::TAG_BITS-1:0];
    v = req.fill_value[acache_pkg::VALUE_BITS-1:0];
    resp = '0;
    resp.read_value = v;
    if (req.req_type == acache_pkg::REQ_PRESET) begin
      // Preset only takes a free line, never evicts
      slot = first_free(n);
      if (slot >= 0) begin
        fill_line(slot, t, v);
        resp.line_kept = 1'b1;
      end
    end else begin
      // Lowest matching valid line answers
      hit_idx = -1;
      for (int i = 0; i < n; i++)
        if (hit_idx < 0 && line_vld_q[i] && line_tag_q[i] == t) hit_idx = i;
      if (hit_idx >= 0) begin
        resp.hit        = 1'b1;
        resp.line_kept  = 1'b1;
        resp.read_value = line_val_q[hit_idx];
        if (policy_q == acache_pkg::POL_LFU) begin
          line_cnt_q[hit_idx] = sat_inc(line_cnt_q[hit_idx]);
        end else begin
          for (int i = 0; i < n; i++)
            if (line_vld_q[i] && i != hit_idx) line_cnt_q[i] = sat_inc(line_cnt_q[i]);
          line_cnt_q[hit_idx] = lru_init_q;
        end
      end else if (n > 0) begin
        // Free line first, else the extreme count, lowest index on ties
        slot = first_free(n);
        if (slot < 0) begin
          slot = 0;
          for (int i = 1; i < n; i++)
            if ((policy_q == acache_pkg::POL_LFU) ? (line_cnt_q[i] < line_cnt_q[slot])
                                                  : (line_cnt_q[i] > line_cnt_q[slot]))
              slot = i;
        end
        fill_line(slot, t, v);
        resp.line_kept = 1'b1;
      end
      // Advance aging after the lookup's own update
      next_age = {1'b0, age_cnt_q} + 17'd1;
      if (next_age >= {1'b0, age_period_q}) begin
        for (int i = 0; i < acache_pkg::LINES; i++) line_cnt_q[i] = line_cnt_q[i] >> 1;
        age_cnt_q = '0;
      end else begin
        age_cnt_q = next_age[15:0];
      end
    end
  endtask

  // Track registers, predict on each request, compare on each response
  always @(posedge clk) begin
    acache_pkg::out_item_t want;
    acache_pkg::out_item_t made;
    if (rst) begin
      for (int i = 0; i < acache_pkg::LINES; i++) begin
        line_tag_q[i] = '0;
        line_val_q[i] = '0;
        line_vld_q[i] = 1'b0;
        line_cnt_q[i] = '0;
      end
      age_cnt_q    = '0;
      policy_q     = acache_pkg::POL_LRU;
      lines_q      = 5'd16;
      lru_init_q   = 8'd0;
      lfu_init_q   = 8'd1;
      age_period_q = 16'd1024;
      queued_resp.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          acache_pkg::CFG_POLICY_MODE:    policy_q     = cfg_data[0];
          acache_pkg::CFG_LINES_IN_USE:   lines_q      = cfg_data[4:0];
          acache_pkg::CFG_LRU_COUNT_INIT: lru_init_q   = cfg_data[7:0];
          acache_pkg::CFG_LFU_COUNT_INIT: lfu_init_q   = cfg_data[7:0];
          acache_pkg::CFG_AGE_PERIOD:     age_period_q = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (queued_resp.size() == 0) begin
          $display("%0t: response with none outstanding: expected none, actual %0d %h %0d",
                   $time, out_data.hit, out_data.read_value, out_data.line_kept);
          fail_count++;
        end else begin
          want = queued_resp.pop_front();
          if (out_data.hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0d, actual %0d",
                     $time, want.hit, out_data.hit);
            fail_count++;
          end
          if (out_data.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.read_value, out_data.read_value);
            fail_count++;
          end
          if (out_data.line_kept !== want.line_kept) begin
            $display("%0t: line_kept mismatch: expected %0d, actual %0d",
                     $time, want.line_kept, out_data.line_kept);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        serve_request(in_data, made);
        queued_resp.push_back(made);
      end
    end
    pending <= queued_resp.size();
  end

endmodule

// ===== bench/tb_assoc_cache_lru_lfu_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_assoc_cache_lru_lfu_top: testbench for the associative LRU/LFU cache
// Drives a directed burst of fills, hits, duplicates, evictions and the
// disabled cache, then phases of random lookups and presets over a small
// tag pool under several register settings, with random idling on both
// channels and one long response hold-off. The checker scores the responses.
// ----------------------------------------------------------------------------
module tb_assoc_cache_lru_lfu_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 2 * acache_pkg::LINES + 8;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 135;
  localparam int POOL_SIZE     = 32;
  localparam int HOLD_CYCLES   = 400;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  acache_pkg::in_item_t              in_data   = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  acache_pkg::out_item_t             out_data;
  logic                              cfg_wr_en = 1'b0;
  logic [acache_pkg::CFG_IDX_W-1:0]  cfg_index = acache_pkg::CFG_POLICY_MODE;
  logic [acache_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int cycle_count;
  bit calm    = 1'b0;
  bit hold_go = 1'b0;
  logic [63:0] tag_pool [POOL_SIZE];

  assoc_cache_lru_lfu_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  acache_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hold reset at the start, then release it
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  // Give up after the cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Response side: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  // Offer one item, with a random gap first, and wait for it to be taken
  task automatic send_item(input logic req, input logic [63:0] t, input logic [63:0] v);
    if (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 22);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: req, tag: t, fill_value: v};
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every response is back and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers on back-to-back cycles
  task automatic write_regs(input logic pol, input int nlines, input int lru_init,
                            input int lfu_init, input int period);
    cfg_wr_en <= 1'b1;
    cfg_index <= acache_pkg::CFG_POLICY_MODE;
    cfg_data  <= acache_pkg::CFG_DATA_W'(pol);
    @(posedge clk);
    cfg_index <= acache_pkg::CFG_LINES_IN_USE;
    cfg_data  <= acache_pkg::CFG_DATA_W'(nlines);
    @(posedge clk);
    cfg_index <= acache_pkg::CFG_LRU_COUNT_INIT;
    cfg_data  <= acache_pkg::CFG_DATA_W'(lru_init);
    @(posedge clk);
    cfg_index <= acache_pkg::CFG_LFU_COUNT_INIT;
    cfg_data  <= acache_pkg::CFG_DATA_W'(lfu_init);
    @(posedge clk);
    cfg_index <= acache_pkg::CFG_AGE_PERIOD;
    cfg_data  <= acache_pkg::CFG_DATA_W'(period);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic        pol;
    int          nlines;
    int          lru_init;
    int          lfu_init;
    int          period;
    int          pool_n;
    logic        req;
    logic [63:0] t;

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = {$urandom, $urandom};

    @(posedge clk);
    while (rst) @(posedge clk);

    // Directed: cold miss, hit, presets, duplicate tag, fill up, full cache
    send_item(acache_pkg::REQ_LOOKUP, 64'd0, 64'd0);
    send_item(acache_pkg::REQ_LOOKUP, 64'd0, '1);
    send_item(acache_pkg::REQ_PRESET, '1, '1);
    send_item(acache_pkg::REQ_LOOKUP, '1, 64'd0);
    send_item(acache_pkg::REQ_PRESET, 64'd0, {$urandom, $urandom});
    send_item(acache_pkg::REQ_LOOKUP, 64'd0, {$urandom, $urandom});
    for (int i = 0; i < acache_pkg::LINES - 3; i++)
      send_item(acache_pkg::REQ_LOOKUP, tag_pool[2 + i], {$urandom, $urandom});
    send_item(acache_pkg::REQ_PRESET, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(acache_pkg::REQ_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom});
    send_item(acache_pkg::REQ_LOOKUP, 64'd0, {$urandom, $urandom});

    // Directed: cache disabled
    settle();
    write_regs(acache_pkg::POL_LFU, 0, 0, 1, 1024);
    send_item(acache_pkg::REQ_LOOKUP, tag_pool[2], {$urandom, $urandom});
    send_item(acache_pkg::REQ_PRESET, tag_pool[3], {$urandom, $urandom});

    // Random phases over a range of register settings
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          pol = acache_pkg::POL_LRU; nlines = 16; lru_init = 0; lfu_init = 1; period = 1024;
        end
        1: begin
          pol = acache_pkg::POL_LFU; nlines = 16; lru_init = 0; lfu_init = 1; period = 65535;
        end
        2: begin
          pol = acache_pkg::POL_LRU; nlines = 4; lru_init = 255; lfu_init = 0; period = 1;
        end
        3: begin
          pol = acache_pkg::POL_LFU; nlines = 1; lru_init = 0; lfu_init = 255; period = 3;
        end
        4: begin
          pol = acache_pkg::POL_LRU; nlines = 0; lru_init = 7; lfu_init = 7; period = 5;
        end
        5: begin
          pol = acache_pkg::POL_LFU; nlines = 8; lru_init = 0; lfu_init = 254; period = 65535;
        end
        6: begin
          pol = acache_pkg::POL_LRU; nlines = 16; lru_init = 250; lfu_init = 0; period = 17;
        end
        7: begin
          pol = acache_pkg::POL_LFU; nlines = 13; lru_init = 128; lfu_init = 128; period = 2;
        end
        default: begin
          pol      = 1'($urandom_range(1));
          nlines   = $urandom_range(16);
          lru_init = $urandom_range(255);
          lfu_init = $urandom_range(255);
          period   = $urandom_range(300, 1);
        end
      endcase
      settle();
      write_regs(pol, nlines, lru_init, lfu_init, period);

      // Refresh part of the pool; size it a little past the enabled lines
      for (int i = 0; i < 4; i++)
        tag_pool[2 + $urandom_range(POOL_SIZE - 3)] = {$urandom, $urandom};
      pool_n = nlines + nlines / 2 + 2;
      if (pool_n > POOL_SIZE) pool_n = POOL_SIZE;
      calm = (p == 6);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 1 && k == 20) hold_go = 1'b1;
        req = ($urandom_range(99) < 15) ? acache_pkg::REQ_PRESET : acache_pkg::REQ_LOOKUP;
        if ($urandom_range(9) == 0) t = {$urandom, $urandom};
        else t = tag_pool[$urandom_range(pool_n - 1)];
        send_item(req, t, {$urandom, $urandom});
      end
    end

    // Drain and report
    calm = 1'b0;
    settle();
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/acache_pkg.sv
src/assoc_cache_lru_lfu_top.sv
bench/acache_checker.sv
bench/tb_assoc_cache_lru_lfu_top.sv
